### rtl/hmu_pkg.sv
// shared types, codes and neighbor tables of the metropolis update unit
`default_nettype none

package hmu_pkg;

	localparam int HMU_LATTICE_SIDE = 64;
	localparam int HMU_EXP_DEPTH    = 256;

	localparam int IN_DATA_W  = 96;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 88;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// number of neighbors visited per proposal, nearest ones first
	localparam int NB_COUNT = 12;
	localparam int NB_NEAR  = 6;

	typedef enum logic [1:0] {
		REQ_LOAD_SPIN = 2'd0,
		REQ_LOAD_BOND = 2'd1,
		REQ_PROPOSE   = 2'd2,
		REQ_READ      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		REG_J1       = 2'd0,
		REG_J3       = 2'd1,
		REG_INV_TEMP = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_NEIGH,
		ST_ACC,
		ST_SAT,
		ST_SCALE,
		ST_LOOK,
		ST_DECIDE,
		ST_DONE
	} state_t;

	// row step of neighbor n; distance-2 neighbors are the nearest ones doubled
	function automatic logic signed [2:0] nb_dr(input logic [3:0] n);
		logic signed [2:0] r;
		unique case (n)
			4'd0, 4'd1: r = 3'sd0;
			4'd2, 4'd3: r = 3'sd1;
			4'd4, 4'd5: r = -3'sd1;
			4'd6, 4'd7: r = 3'sd0;
			4'd8, 4'd9: r = 3'sd2;
			4'd10, 4'd11: r = -3'sd2;
			default: r = 3'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [2:0] nb_dc(input logic [3:0] n);
		logic signed [2:0] c;
		unique case (n)
			4'd0, 4'd3: c = 3'sd1;
			4'd1, 4'd5: c = -3'sd1;
			4'd2, 4'd4: c = 3'sd0;
			4'd6, 4'd9: c = 3'sd2;
			4'd7, 4'd11: c = -3'sd2;
			4'd8, 4'd10: c = 3'sd0;
			default: c = 3'sd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/heisenberg_metropolis_update_unit.sv
// metropolis update engine for 3-component spins on a periodic triangular lattice
`default_nettype none

// Metropolis update unit. Items arrive on the s_axis side (tuser = request kind) and each one
// gives exactly one result beat on the m_axis side. A load or a read passes the decode and done
// states before its result beat. A proposal, after decode, visits the 12 neighbors (6 nearest,
// 6 at distance 2) one after another, each on the single shared 35x17 signed multiplier (three
// spin component products, then the dot product times the coupling). After that the multiplier
// scales dE by inv_temp, the exponential table is read once, and the accepted spin is written
// back. One item is in work at a time; the next item can be taken while the previous result
// still waits in the output register. Spins and bond offsets live in two memories with one
// read and one write port each and registered read data, and are undefined until loaded; a
// proposal touching an unloaded entry gives undefined results. Sites outside the lattice are
// ignored (loads do nothing, reads and proposals answer zeros). Coupling registers are written
// over the APB port and should only change while no item is in work.
module heisenberg_metropolis_update_unit
	import hmu_pkg::*;
#(
	parameter int LATTICE_SIDE    = HMU_LATTICE_SIDE,
	parameter int EXP_TABLE_DEPTH = HMU_EXP_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input beats
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// site, bond, spin_x, spin_y, spin_z, coupling_offset, random_draw
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// req_type
	input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
	// result beats
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// accepted, energy_diff, read_x, read_y, read_z
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// configuration
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int NSITES  = LATTICE_SIDE * LATTICE_SIDE;
	localparam int AW      = $clog2(NSITES);
	localparam int OW      = $clog2(NSITES * NB_NEAR);
	localparam int RW      = $clog2(LATTICE_SIDE);
	localparam int EW      = $clog2(EXP_TABLE_DEPTH);
	// reciprocal of the side for row = site / side
	localparam logic [63:0] RECIP = 64'((64'd1 << 32) + 64'(LATTICE_SIDE) - 64'd1)
		/ 64'(LATTICE_SIDE);
	localparam logic [2:0] PH_LAST = 3'd4;

	typedef logic [15:0] exp_rom_t [EXP_TABLE_DEPTH];

	// entry k = exp(-k/16) in Q0.16 from a rounded Q0.32 decay recurrence
	function automatic exp_rom_t build_exp();
		exp_rom_t t;
		logic [95:0] p;
		logic [95:0] e;
		p = 96'd1 << 32;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			e = (p + 96'h8000) >> 16;
			t[k] = (e > 96'd65535) ? 16'hffff : e[15:0];
			p = (p * 96'd4034748381 + 96'h8000_0000) >> 32;
		end
		return t;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp();

	function automatic logic [RW-1:0] wrap(input logic [RW-1:0] v, input logic signed [2:0] d);
		int t;
		t = int'(v) + int'(d);
		if (t < 0) begin
			t = t + LATTICE_SIDE;
		end else if (t >= LATTICE_SIDE) begin
			t = t - LATTICE_SIDE;
		end
		return RW'(t);
	endfunction

	// input fields
	logic [11:0] in_site;
	logic [2:0]  in_bond;
	logic [47:0] in_spin;
	logic [15:0] in_off;
	logic [15:0] in_draw;
	assign in_site = s_axis_tdata[11:0];
	assign in_bond = s_axis_tdata[14:12];
	assign in_spin = s_axis_tdata[62:15];
	assign in_off  = s_axis_tdata[78:63];
	assign in_draw = s_axis_tdata[94:79];

	// configuration registers
	logic [15:0] j1_q, j3_q, inv_temp_q;
	reg_idx_t    reg_sel;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j1_q       <= '0;
			j3_q       <= '0;
			inv_temp_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_J1:       j1_q       <= pwdata[15:0];
				REG_J3:       j3_q       <= pwdata[15:0];
				REG_INV_TEMP: inv_temp_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_J1:       prdata = {16'd0, j1_q};
			REG_J3:       prdata = {16'd0, j3_q};
			REG_INV_TEMP: prdata = {16'd0, inv_temp_q};
			default:      prdata = '0;
		endcase
	end

	// sequencer and item registers
	state_t state_q, state_d;
	logic [2:0]  ph_q;
	logic [3:0]  nb_q;
	req_t        req_q;
	logic        site_ok_q;
	logic [AW-1:0] site_q;
	logic [RW-1:0] row_q, col_q;
	logic [2:0]  bond_q;
	logic [47:0] new_q;
	logic [15:0] off_in_q;
	logic [15:0] draw_q;

	logic in_fire, out_free;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// memories
	logic [47:0] spin_mem [NSITES];
	logic [15:0] off_mem [NSITES * NB_NEAR];
	logic [47:0] spin_rd_q;
	logic [15:0] off_rd_q;
	logic [AW-1:0] spin_raddr, spin_waddr;
	logic [OW-1:0] off_raddr;
	logic          spin_we, off_we;
	logic [47:0]   spin_wdata;

	// datapath registers
	logic signed [16:0] dx_q, dy_q, dz_q;
	logic [47:0]        old_q;
	logic signed [34:0] dot_q;
	logic signed [51:0] prod_q;
	logic signed [55:0] acc_q;
	logic signed [31:0] de_q;
	logic [15:0]        exp_q;
	logic               idx_ok_q;
	logic               res_acc_q;
	logic signed [31:0] res_de_q;
	logic [47:0]        res_spin_q;

	// shared multiplier
	logic signed [34:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [51:0] mul_p;
	assign mul_p = 52'(mul_a * mul_b);

	logic [3:0]     rd_nb;
	logic [RW-1:0]  nb_row, nb_col;
	logic signed [16:0] coup;
	logic signed [32:0] de_wide;
	logic [31:0]    exp_idx;
	logic           accept_now;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_DECODE;
			ST_DECODE: state_d = (site_ok_q && req_q == REQ_PROPOSE) ? ST_NEIGH : ST_DONE;
			ST_NEIGH:  if (ph_q == PH_LAST && nb_q == 4'(NB_COUNT - 1)) state_d = ST_ACC;
			ST_ACC:    state_d = ST_SAT;
			ST_SAT:    state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_LOOK;
			ST_LOOK:   state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		// next read is issued in the last phase so data is ready at phase zero
		if (state_q == ST_NEIGH && ph_q == PH_LAST) begin
			rd_nb = nb_q + 4'd1;
		end else if (state_q == ST_NEIGH) begin
			rd_nb = nb_q;
		end else begin
			rd_nb = '0;
		end
		nb_row = wrap(row_q, nb_dr(rd_nb));
		nb_col = wrap(col_q, nb_dc(rd_nb));
		spin_raddr = (state_q == ST_IDLE) ? AW'(in_site)
			: AW'(int'(nb_row) * LATTICE_SIDE + int'(nb_col));
		off_raddr = OW'(int'(site_q) * NB_NEAR + ((rd_nb < 4'(NB_NEAR)) ? int'(rd_nb) : 0));

		spin_we    = 1'b0;
		spin_waddr = site_q;
		spin_wdata = new_q;
		off_we     = (state_q == ST_DECODE) && site_ok_q && (req_q == REQ_LOAD_BOND)
			&& (bond_q < 3'(NB_NEAR));
		if (state_q == ST_DECODE && site_ok_q && req_q == REQ_LOAD_SPIN) begin
			spin_we = 1'b1;
		end else if (state_q == ST_DECIDE && accept_now) begin
			spin_we = 1'b1;
		end

		coup = (nb_q < 4'(NB_NEAR)) ? (17'(signed'(j1_q)) + 17'(signed'(off_rd_q)))
			: 17'(signed'(j3_q));

		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_NEIGH) begin
			unique case (ph_q)
				3'd0: begin
					mul_a = 35'(dx_q);
					mul_b = 17'(signed'(spin_rd_q[15:0]));
				end
				3'd1: begin
					mul_a = 35'(dy_q);
					mul_b = 17'(signed'(spin_rd_q[31:16]));
				end
				3'd2: begin
					mul_a = 35'(dz_q);
					mul_b = 17'(signed'(spin_rd_q[47:32]));
				end
				3'd4: begin
					mul_a = dot_q;
					mul_b = coup;
				end
				default: ;
			endcase
		end else if (state_q == ST_SCALE) begin
			mul_a = 35'(de_q);
			mul_b = signed'({1'b0, inv_temp_q});
		end
	end

	// floor to units of 2^-16 is an arithmetic shift
	assign de_wide = 33'(acc_q >>> 23);
	assign exp_idx = prod_q[51:20];
	assign accept_now = (de_q <= 0) || (inv_temp_q == 16'd0)
		|| (idx_ok_q && (draw_q < exp_q));

	always_ff @(posedge clk) begin
		if (spin_we) begin
			spin_mem[spin_waddr] <= spin_wdata;
		end
		spin_rd_q <= spin_mem[spin_raddr];
	end

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[OW'(int'(site_q) * NB_NEAR + int'(bond_q))] <= off_in_q;
		end
		off_rd_q <= off_mem[off_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ph_q          <= '0;
			nb_q          <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_NEIGH) begin
				ph_q <= (ph_q == PH_LAST) ? 3'd0 : ph_q + 3'd1;
				if (ph_q == PH_LAST) nb_q <= nb_q + 4'd1;
			end else begin
				ph_q <= '0;
				nb_q <= '0;
			end
			if (state_q == ST_DONE && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	logic [11:0] row_full;
	assign row_full = 12'((45'(in_site) * 45'(RECIP)) >> 32);

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_fire) begin
			req_q     <= req_t'(s_axis_tuser);
			site_ok_q <= 32'(in_site) < 32'(NSITES);
			site_q    <= AW'(in_site);
			row_q     <= RW'(row_full);
			col_q     <= RW'(in_site - 12'(int'(row_full) * LATTICE_SIDE));
			bond_q    <= in_bond;
			new_q     <= in_spin;
			off_in_q  <= in_off;
			draw_q    <= in_draw;
		end
		unique case (state_q)
			ST_DECODE: begin
				old_q      <= spin_rd_q;
				dx_q       <= 17'(signed'(new_q[15:0])) - 17'(signed'(spin_rd_q[15:0]));
				dy_q       <= 17'(signed'(new_q[31:16])) - 17'(signed'(spin_rd_q[31:16]));
				dz_q       <= 17'(signed'(new_q[47:32])) - 17'(signed'(spin_rd_q[47:32]));
				acc_q      <= '0;
				res_acc_q  <= 1'b0;
				res_de_q   <= '0;
				res_spin_q <= (site_ok_q && req_q == REQ_READ) ? spin_rd_q : '0;
			end
			ST_NEIGH: begin
				unique case (ph_q)
					3'd0: if (nb_q != 4'd0) acc_q <= acc_q + 56'(prod_q);
					3'd1: dot_q <= prod_q[34:0];
					3'd2, 3'd3: dot_q <= dot_q + prod_q[34:0];
					default: ;
				endcase
			end
			ST_ACC: acc_q <= acc_q + 56'(prod_q);
			ST_SAT: begin
				// saturate to signed 32 bits
				if (de_wide > 33'sh0_7fff_ffff) begin
					de_q <= 32'sh7fff_ffff;
				end else if (de_wide < -33'sh0_8000_0000) begin
					de_q <= 32'sh8000_0000;
				end else begin
					de_q <= de_wide[31:0];
				end
			end
			ST_LOOK: begin
				idx_ok_q <= exp_idx < 32'(EXP_TABLE_DEPTH);
				exp_q    <= EXP_ROM[exp_idx[EW-1:0]];
			end
			ST_DECIDE: begin
				res_acc_q  <= accept_now;
				res_de_q   <= de_q;
				res_spin_q <= accept_now ? new_q : old_q;
			end
			ST_DONE: if (out_free) begin
				m_axis_tdata <= {7'd0, res_spin_q, res_de_q, res_acc_q};
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### rtl/hmu_checker.sv
// port-level checks of the metropolis update unit, bound to the top level
`default_nettype none

module hmu_port_checks
	import hmu_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// one item in work: no new beat right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// an energy drop is always accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[0])
		else $error("negative energy change rejected");

	// no result beat without a preceding input beat stream start
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !s_axis_tready || !$past(s_axis_tready))
		else $error("result appeared without an item in work");

endmodule

bind heisenberg_metropolis_update_unit hmu_port_checks u_hmu_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
